### hw/rtl/gfcc_pkg.sv
// ----------------------------------------------------------------------------
// gfcc_pkg: shared types and constants for the grid footprint collision check
// Register indexes, request codes, datapath widths and the Q15.16 saturator.
// ----------------------------------------------------------------------------
package gfcc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd4;

	// register reset values
	localparam logic [15:0]        RST_GRID_WIDTH = 16'd256;
	localparam logic [31:0]        RST_CELL_SIZE  = 32'd3277;
	localparam logic signed [7:0]  RST_THRESHOLD  = 8'sd50;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_POSE  = 1'b1;

	// divider operand width
	localparam int DIV_W = 32;

	// flat cell index width: covers row * width + column for any pose
	localparam int KW = 52;

	// hit coordinate sum width before saturation
	localparam int SUM_W = 54;

	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;

	typedef logic signed [SUM_W-1:0] sum_t;

	function automatic logic signed [31:0] sat32(input sum_t v);
		logic signed [31:0] r;
		if (v > SUM_W'(SAT_HI)) begin
			r = 32'sh7fffffff;
		end else if (v < SUM_W'(SAT_LO)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/grid_footprint_collision_check_top.sv
// ----------------------------------------------------------------------------
// grid_footprint_collision_check_top: occupancy grid footprint collision check
// A cell write takes effect at its accept edge and gives no result. A pose
// runs the two cell divisions, then one grid read per cycle over up to
// (2*HALF_WINDOW)^2 cells, stopping at the first hit, then resolves a hit's
// coordinates with a further division and two multiplies.
// The divider is a shared bit-serial unit and the grid has a single read port.
// One request at a time; done strobes the result for one cycle, no stall.
// Reset clears control state, configuration and result registers; grid contents are not cleared.
// ----------------------------------------------------------------------------
module grid_footprint_collision_check_top #(
	parameter int GRID_CELLS  = 65536,
	parameter int HALF_WINDOW = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,

	// request channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                req_type,
	input  logic [15:0]                         cell_address,
	input  logic signed [7:0]                   cell_value,
	input  logic signed [31:0]                  pose_x,
	input  logic signed [31:0]                  pose_y,

	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gfcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,

	// result strobe
	output logic                                done,
	output logic                                collision,
	output logic                                new_collision,
	output logic [15:0]                         hit_index,
	output logic signed [31:0]                  hit_x,
	output logic signed [31:0]                  hit_y
);

	localparam int AW  = $clog2(GRID_CELLS);
	localparam int XW  = (AW > 16) ? AW : 16;
	localparam int MW  = AW + 32;
	localparam int WIN = 2 * HALF_WINDOW;
	localparam int CW  = $clog2(WIN);
	localparam int KW  = gfcc_pkg::KW;
	localparam int DW  = gfcc_pkg::DIV_W;

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIVX = 4'd1;  // column = (x - ox) / cell size
	localparam logic [3:0] ST_DIVY = 4'd2;  // row    = (y - oy) / cell size
	localparam logic [3:0] ST_MUL  = 4'd3;  // row * width, half window offset
	localparam logic [3:0] ST_BASE = 4'd4;  // first window index
	localparam logic [3:0] ST_SCAN = 4'd5;  // one grid read per cycle
	localparam logic [3:0] ST_HDIV = 4'd6;  // hit / width -> row, column
	localparam logic [3:0] ST_MULX = 4'd7;
	localparam logic [3:0] ST_MULY = 4'd8;
	localparam logic [3:0] ST_SATY = 4'd9;

	// ---------------- configuration registers ----------------
	logic [15:0]        grid_width_q;
	logic [31:0]        cell_size_q;
	logic signed [31:0] origin_x_q;
	logic signed [31:0] origin_y_q;
	logic signed [7:0]  thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q <= gfcc_pkg::RST_GRID_WIDTH;
			cell_size_q  <= gfcc_pkg::RST_CELL_SIZE;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			thr_q        <= gfcc_pkg::RST_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gfcc_pkg::REG_GRID_WIDTH: grid_width_q <= cfg_data[15:0];
				gfcc_pkg::REG_CELL_SIZE:  cell_size_q  <= cfg_data;
				gfcc_pkg::REG_ORIGIN_X:   origin_x_q   <= cfg_data;
				gfcc_pkg::REG_ORIGIN_Y:   origin_y_q   <= cfg_data;
				gfcc_pkg::REG_THRESHOLD:  thr_q        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// zero width and zero cell size act as one
	logic [15:0]          w_eff;
	logic [31:0]          cs_eff;
	logic signed [KW-1:0] w_k;

	assign w_eff  = (grid_width_q == '0) ? 16'd1 : grid_width_q;
	assign cs_eff = (cell_size_q == '0) ? 32'd1 : cell_size_q;
	assign w_k    = KW'($signed({1'b0, w_eff}));

	// ---------------- request accept ----------------
	logic [3:0] state_q;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// pose offsets from the origin: magnitude below 2^32, sign kept apart
	logic signed [32:0] diffx;
	logic signed [32:0] diffy;
	logic signed [32:0] negx;
	logic signed [32:0] negy;

	assign diffx = 33'(pose_x) - 33'(origin_x_q);
	assign diffy = 33'(pose_y) - 33'(origin_y_q);
	assign negx  = -diffx;
	assign negy  = -diffy;

	// ---------------- grid memory ----------------
	logic [7:0]    mem [GRID_CELLS];
	logic [XW-1:0] wa_ext;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;

	assign wa_ext = XW'(cell_address);
	assign wr_en  = accept && (req_type == gfcc_pkg::REQ_WRITE) &&
	                (32'(cell_address) < 32'(GRID_CELLS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa_ext[AW-1:0]] <= cell_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// ---------------- shared divider ----------------
	logic          kick_q;
	logic [DW-1:0] div_dividend;
	logic [DW-1:0] div_divisor;
	logic          div_done;
	logic [DW-1:0] div_quot;
	logic [DW-1:0] div_rem;
	logic [31:0]   magx_q;
	logic [31:0]   magy_q;
	logic          sgnx_q;
	logic          sgny_q;
	logic [AW-1:0] hit_q;

	always_comb begin
		case (state_q)
			ST_DIVX: begin
				div_dividend = magx_q;
				div_divisor  = cs_eff;
			end
			ST_DIVY: begin
				div_dividend = magy_q;
				div_divisor  = cs_eff;
			end
			default: begin
				div_dividend = DW'(hit_q);
				div_divisor  = DW'(w_eff);
			end
		endcase
	end

	gfcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kick_q),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	logic signed [32:0] quot_s;
	assign quot_s = $signed({1'b0, div_quot});

	// ---------------- window scan ----------------
	logic signed [32:0]   col_q;
	logic signed [32:0]   row_q;
	logic signed [KW-1:0] prod_q;
	logic signed [KW-1:0] hw_q;
	logic signed [KW-1:0] kcol_q;   // index at top of current column
	logic signed [KW-1:0] k_q;      // index being read
	logic [CW-1:0]        dx_q;
	logic [CW-1:0]        dy_q;
	logic                 issue_done_q;
	logic                 chk_s1;   // a real read is in flight
	logic [AW-1:0]        k_s1;
	logic                 k_in_range;
	logic                 hit_now;

	assign k_in_range = !k_q[KW-1] && (k_q < $signed(KW'(GRID_CELLS)));
	assign rd_addr    = k_q[AW-1:0];
	assign rd_en      = (state_q == ST_SCAN) && !issue_done_q && k_in_range;
	assign hit_now    = chk_s1 && ($signed(rd_data_q) > thr_q);

	// ---------------- hit coordinates ----------------
	logic [AW-1:0]      mul_op;
	logic [MW-1:0]      mul_q;
	logic signed [31:0] hx_q;
	gfcc_pkg::sum_t     sum_x;
	gfcc_pkg::sum_t     sum_y;

	assign mul_op = (state_q == ST_MULX) ? div_rem[AW-1:0] : div_quot[AW-1:0];
	assign sum_x  = $signed(gfcc_pkg::SUM_W'(mul_q)) + gfcc_pkg::SUM_W'(origin_x_q);
	assign sum_y  = $signed(gfcc_pkg::SUM_W'(mul_q)) + gfcc_pkg::SUM_W'(origin_y_q);

	// ---------------- result registers ----------------
	logic               done_q;
	logic               coll_q;
	logic               new_q;
	logic [15:0]        hidx_q;
	logic signed [31:0] hitx_q;
	logic signed [31:0] hity_q;
	logic               prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kick_q       <= 1'b0;
			issue_done_q <= 1'b0;
			chk_s1       <= 1'b0;
			done_q       <= 1'b0;
			coll_q       <= 1'b0;
			new_q        <= 1'b0;
			hidx_q       <= '0;
			hitx_q       <= '0;
			hity_q       <= '0;
			prev_q       <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == gfcc_pkg::REQ_POSE)) begin
						state_q <= ST_DIVX;
						kick_q  <= 1'b1;
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						state_q <= ST_DIVY;
						kick_q  <= 1'b1;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					state_q      <= ST_SCAN;
					issue_done_q <= 1'b0;
					chk_s1       <= 1'b0;
				end
				ST_SCAN: begin
					if (hit_now) begin
						// first occupied cell: stop and resolve its coordinates
						chk_s1  <= 1'b0;
						state_q <= ST_HDIV;
						kick_q  <= 1'b1;
					end else if (issue_done_q) begin
						// window exhausted, no obstacle
						chk_s1  <= 1'b0;
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						coll_q  <= 1'b0;
						new_q   <= 1'b0;
						hidx_q  <= '0;
						hitx_q  <= '0;
						hity_q  <= '0;
						prev_q  <= 1'b0;
					end else begin
						chk_s1 <= k_in_range;
						if ((dx_q == CW'(WIN - 1)) && (dy_q == CW'(WIN - 1))) begin
							issue_done_q <= 1'b1;
						end
					end
				end
				ST_HDIV: begin
					if (div_done) begin
						state_q <= ST_MULX;
					end
				end
				ST_MULX: begin
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					state_q <= ST_SATY;
				end
				ST_SATY: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					coll_q  <= 1'b1;
					new_q   <= !prev_q;
					hidx_q  <= 16'(hit_q);
					hitx_q  <= hx_q;
					hity_q  <= gfcc_pkg::sat32(sum_y);
					prev_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept && (req_type == gfcc_pkg::REQ_POSE)) begin
			sgnx_q <= diffx[32];
			sgny_q <= diffy[32];
			magx_q <= diffx[32] ? negx[31:0] : diffx[31:0];
			magy_q <= diffy[32] ? negy[31:0] : diffy[31:0];
		end
		if ((state_q == ST_DIVX) && div_done) begin
			col_q <= sgnx_q ? -quot_s : quot_s;
		end
		if ((state_q == ST_DIVY) && div_done) begin
			row_q <= sgny_q ? -quot_s : quot_s;
		end
		if (state_q == ST_MUL) begin
			prod_q <= KW'(row_q) * w_k;
			hw_q   <= w_k * KW'(HALF_WINDOW);
		end
		if (state_q == ST_BASE) begin
			kcol_q <= prod_q + KW'(col_q) - hw_q - KW'(HALF_WINDOW);
			k_q    <= prod_q + KW'(col_q) - hw_q - KW'(HALF_WINDOW);
			dx_q   <= '0;
			dy_q   <= '0;
		end
		if ((state_q == ST_SCAN) && !hit_now && !issue_done_q) begin
			k_s1 <= k_q[AW-1:0];
			if (dy_q == CW'(WIN - 1)) begin
				// next column of offsets
				dy_q   <= '0;
				dx_q   <= dx_q + 1'b1;
				kcol_q <= kcol_q + KW'(1);
				k_q    <= kcol_q + KW'(1);
			end else begin
				dy_q <= dy_q + 1'b1;
				k_q  <= k_q + w_k;
			end
		end
		if ((state_q == ST_SCAN) && hit_now) begin
			hit_q <= k_s1;
		end
		if ((state_q == ST_MULX) || (state_q == ST_MULY)) begin
			mul_q <= MW'(mul_op) * MW'(cs_eff);
		end
		if (state_q == ST_MULY) begin
			hx_q <= gfcc_pkg::sat32(sum_x);
		end
	end

	assign done          = done_q;
	assign collision     = coll_q;
	assign new_collision = new_q;
	assign hit_index     = hidx_q;
	assign hit_x         = hitx_q;
	assign hit_y         = hity_q;

endmodule

### hw/rtl/gfcc_div.sv
// ----------------------------------------------------------------------------
// gfcc_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; results hold until next start.
// ----------------------------------------------------------------------------
module gfcc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [gfcc_pkg::DIV_W-1:0]   dividend,
	input  logic [gfcc_pkg::DIV_W-1:0]   divisor,
	output logic                         done,
	output logic [gfcc_pkg::DIV_W-1:0]   quot,
	output logic [gfcc_pkg::DIV_W-1:0]   rem
);

	localparam int CNT_W = $clog2(gfcc_pkg::DIV_W + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	logic [gfcc_pkg::DIV_W-1:0]  quo_q;
	logic [gfcc_pkg::DIV_W-1:0]  rem_q;
	logic [gfcc_pkg::DIV_W-1:0]  dsr_q;
	logic [gfcc_pkg::DIV_W:0]    rem_sh;
	logic [gfcc_pkg::DIV_W:0]    trial;

	assign rem_sh = {rem_q, quo_q[gfcc_pkg::DIV_W-1]};
	assign trial  = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(gfcc_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[gfcc_pkg::DIV_W]) begin
				rem_q <= trial[gfcc_pkg::DIV_W-1:0];
				quo_q <= {quo_q[gfcc_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[gfcc_pkg::DIV_W-1:0];
				quo_q <= {quo_q[gfcc_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

### sim/collision_check_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collision_check_monitor: result checker for the grid footprint collision check
// Watches the request, register and result channels, keeps its own copy of the
// grid and registers, predicts each pose verdict and compares it on done.
// ----------------------------------------------------------------------------
module collision_check_monitor #(
	parameter int GRID_CELLS  = 65536,
	parameter int HALF_WINDOW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           req_type,
	input  logic [15:0]                    cell_address,
	input  logic signed [7:0]              cell_value,
	input  logic signed [31:0]             pose_x,
	input  logic signed [31:0]             pose_y,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gfcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           done,
	input  logic                           collision,
	input  logic                           new_collision,
	input  logic [15:0]                    hit_index,
	input  logic signed [31:0]             hit_x,
	input  logic signed [31:0]             hit_y,
	output int                             fail_count,
	output int                             outstanding,
	output int                             collisions_seen
);
	import gfcc_pkg::*;

	typedef struct packed {
		logic        collision;
		logic        new_collision;
		logic [15:0] hit_index;
		logic [31:0] hit_x;
		logic [31:0] hit_y;
	} verdict_t;

	logic signed [7:0]  grid_copy [GRID_CELLS];
	logic               last_pose_hit;
	logic [15:0]        width_reg;
	logic [31:0]        cell_size_reg;
	logic signed [31:0] origin_x_reg;
	logic signed [31:0] origin_y_reg;
	logic signed [7:0]  threshold_reg;

	verdict_t pending_verdicts [$];
	verdict_t want;
	int       mismatches;
	int       hits;

	function automatic longint clamp_q16(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// cell from pose, then column-major scan of the window, first obstacle wins
	task automatic predict_pose_verdict(input logic signed [31:0] px,
					    input logic signed [31:0] py);
		longint   w;
		longint   cs;
		longint   col;
		longint   row;
		longint   base;
		longint   k;
		longint   hit;
		bit       found;
		verdict_t v;
		w = (width_reg == 16'd0) ? 64'sd1 : longint'(width_reg);
		cs = (cell_size_reg == 32'd0) ? 64'sd1 : longint'(cell_size_reg);
		col = (longint'(px) - longint'(origin_x_reg)) / cs;
		row = (longint'(py) - longint'(origin_y_reg)) / cs;
		base = row * w + col;
		found = 1'b0;
		hit = 0;
		for (int dx = -HALF_WINDOW; dx < HALF_WINDOW && !found; dx++) begin
			for (int dy = -HALF_WINDOW; dy < HALF_WINDOW && !found; dy++) begin
				k = base + longint'(dy) * w + longint'(dx);
				if (k >= 0 && k < GRID_CELLS) begin
					if (grid_copy[int'(k)] > threshold_reg) begin
						found = 1'b1;
						hit = k;
					end
				end
			end
		end
		v = '0;
		v.collision = found;
		v.new_collision = found && !last_pose_hit;
		if (found) begin
			v.hit_index = 16'(hit);
			v.hit_x = 32'(clamp_q16((hit % w) * cs + longint'(origin_x_reg)));
			v.hit_y = 32'(clamp_q16((hit / w) * cs + longint'(origin_y_reg)));
		end
		last_pose_hit = found;
		pending_verdicts.push_back(v);
	endtask

	task automatic flag_field(input string field, input longint exp_val, input longint got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pose_hit = 1'b0;
			width_reg = RST_GRID_WIDTH;
			cell_size_reg = RST_CELL_SIZE;
			origin_x_reg = '0;
			origin_y_reg = '0;
			threshold_reg = RST_THRESHOLD;
			pending_verdicts.delete();
			mismatches = 0;
			hits = 0;
			fail_count <= 0;
			outstanding <= 0;
			collisions_seen <= 0;
		end else begin
			// results first: a request accepted at this edge predicts after them
			if (done) begin
				if (pending_verdicts.size() == 0) begin
					$error("result with no pose request waiting");
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					flag_field("collision", longint'(want.collision), longint'(collision));
					flag_field("new_collision", longint'(want.new_collision),
						   longint'(new_collision));
					flag_field("hit_index", longint'(want.hit_index), longint'(hit_index));
					flag_field("hit_x", longint'($signed(want.hit_x)), longint'(hit_x));
					flag_field("hit_y", longint'($signed(want.hit_y)), longint'(hit_y));
				end
				if (collision)
					hits++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GRID_WIDTH: width_reg = cfg_data[15:0];
					REG_CELL_SIZE:  cell_size_reg = cfg_data;
					REG_ORIGIN_X:   origin_x_reg = cfg_data;
					REG_ORIGIN_Y:   origin_y_reg = cfg_data;
					REG_THRESHOLD:  threshold_reg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE) begin
					if (int'(cell_address) < GRID_CELLS)
						grid_copy[cell_address] = cell_value;
				end else begin
					predict_pose_verdict(pose_x, pose_y);
				end
			end
			fail_count <= mismatches;
			outstanding <= pending_verdicts.size();
			collisions_seen <= hits;
		end
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the grid footprint collision check
// Fills the whole grid, runs a directed set of writes and poses, then random
// traffic under several register settings with random request gaps. The
// monitor predicts and checks every pose verdict; this module drives stimulus.
// ----------------------------------------------------------------------------
module tb_top;
	import gfcc_pkg::*;

	localparam int     GRID_CELLS    = 65536;
	localparam int     HALF_WINDOW   = 5;
	localparam int     PHASES        = 8;
	localparam int     RANDOM_ITEMS  = 1530;
	localparam int     SETTLE_CYCLES = 300;
	// covers the init pass plus ~1600 requests with margin
	localparam longint CYCLE_LIMIT   = 3000000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [15:0]           cell_address;
	logic signed [7:0]     cell_value;
	logic signed [31:0]    pose_x;
	logic signed [31:0]    pose_y;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [31:0]           cfg_data;
	logic                  done;
	logic                  collision;
	logic                  new_collision;
	logic [15:0]           hit_index;
	logic signed [31:0]    hit_x;
	logic signed [31:0]    hit_y;

	int fail_count;
	int outstanding;
	int collisions_seen;

	longint cycles = 0;
	int     n_requests = 0;
	int     n_poses = 0;
	int     n_settings = 1;   // the reset setting counts

	// stimulus side view of the active setting (zero width / size act as 1)
	longint cur_w;
	longint cur_cs;
	longint cur_ox;
	longint cur_oy;

	bit                 no_idle;
	int                 target;
	int                 roll;
	int                 dx;
	int                 dy;
	logic [15:0]        addr;
	logic signed [31:0] px;
	logic signed [31:0] py;

	grid_footprint_collision_check_top #(
		.GRID_CELLS  (GRID_CELLS),
		.HALF_WINDOW (HALF_WINDOW)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.cell_address  (cell_address),
		.cell_value    (cell_value),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.collision     (collision),
		.new_collision (new_collision),
		.hit_index     (hit_index),
		.hit_x         (hit_x),
		.hit_y         (hit_y)
	);

	collision_check_monitor #(
		.GRID_CELLS  (GRID_CELLS),
		.HALF_WINDOW (HALF_WINDOW)
	) monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.cell_address    (cell_address),
		.cell_value      (cell_value),
		.pose_x          (pose_x),
		.pose_y          (pose_y),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.collision       (collision),
		.new_collision   (new_collision),
		.hit_index       (hit_index),
		.hit_x           (hit_x),
		.hit_y           (hit_y),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.collisions_seen (collisions_seen)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// occupancy value in the legal range, -1 (unknown) through 100
	function automatic logic signed [7:0] any_cell_value();
		return 8'($signed($urandom_range(0, 101)) - 1);
	endfunction

	// One request. The gap is drawn per request; start is left high after the
	// accept so back-to-back requests never drop it within one time step.
	task automatic issue_request(input logic kind, input logic [15:0] a,
				     input logic signed [7:0] v,
				     input logic signed [31:0] x, input logic signed [31:0] y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		cell_address <= a;
		cell_value <= v;
		pose_x <= x;
		pose_y <= y;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_requests++;
		if (kind == REQ_POSE)
			n_poses++;
	endtask

	// unused fields carry random content
	task automatic send_write(input logic [15:0] a, input logic signed [7:0] v);
		issue_request(REQ_WRITE, a, v, $urandom, $urandom);
	endtask

	task automatic send_pose(input logic signed [31:0] x, input logic signed [31:0] y);
		issue_request(REQ_POSE, 16'($urandom), any_cell_value(), x, y);
	endtask

	// hold off until every predicted verdict has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// New setting, only with the block idle: results drained, a cell write
	// given time to finish, busy low.
	task automatic apply_setting(input logic [15:0] w, input logic [31:0] cs,
				     input logic signed [31:0] ox, input logic signed [31:0] oy,
				     input logic signed [7:0] thr);
		drain_results();
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
		write_reg(REG_GRID_WIDTH, {16'h0, w});
		write_reg(REG_CELL_SIZE, cs);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_THRESHOLD, {{24{thr[7]}}, thr});
		cfg_valid <= 1'b0;
		cur_w = (w == 16'd0) ? 64'sd1 : longint'(w);
		cur_cs = (cs == 32'd0) ? 64'sd1 : longint'(cs);
		cur_ox = longint'(ox);
		cur_oy = longint'(oy);
		n_settings++;
	endtask

	// Pose that lands in flat cell t under the active setting, with a random
	// sub-cell offset; now and then the offset goes negative so truncation
	// toward zero gets exercised. Large settings simply wrap.
	function automatic void pose_at_cell(input int t, output logic signed [31:0] x,
					     output logic signed [31:0] y);
		longint fx;
		longint fy;
		fx = longint'($urandom) % cur_cs;
		fy = longint'($urandom) % cur_cs;
		if ($urandom_range(0, 9) == 0)
			fx = -fx;
		if ($urandom_range(0, 9) == 0)
			fy = -fy;
		x = 32'(cur_ox + (longint'(t) % cur_w) * cur_cs + fx);
		y = 32'(cur_oy + (longint'(t) / cur_w) * cur_cs + fy);
	endfunction

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_WRITE;
		cell_address <= '0;
		cell_value <= '0;
		pose_x <= '0;
		pose_y <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_GRID_WIDTH;
		cfg_data <= '0;
		cur_w = longint'(RST_GRID_WIDTH);
		cur_cs = longint'(RST_CELL_SIZE);
		cur_ox = 0;
		cur_oy = 0;
		target = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The grid is not cleared by reset: write every cell once, mostly
		// free values, so no pose ever reads an unwritten cell.
		no_idle = 1'b1;
		for (int a = 0; a < GRID_CELLS; a++)
			send_write(16'(a), 8'($signed($urandom_range(0, 41)) - 1));

		// ---- directed, reset setting: 256 wide, 3277 per cell, threshold 50
		no_idle = 1'b0;
		// window partly below index 0, all free
		send_pose(32'sd0, 32'sd0);
		// obstacle at max value, then a rising edge and a held collision
		send_write(16'd3, 8'sd100);
		send_pose(32'sd0, 32'sd0);
		send_pose(32'sd0, 32'sd0);
		// unknown (-1) clears it; collision drops
		send_write(16'd3, -8'sd1);
		send_pose(32'sd3277, 32'sd3277);
		// just above threshold at the end of row 9, found from column 0 of
		// row 10 because the window wraps across the row edge
		send_write(16'd2559, 8'sd51);
		send_pose(32'sd0, 32'(10 * 3277));
		// equal to threshold is free
		send_write(16'd2559, 8'sd50);
		send_pose(32'sd0, 32'(10 * 3277));
		// slightly negative pose truncates to cell 0, where only cell 260 hits
		send_write(16'd260, 8'sd80);
		send_pose(-32'sd1, -32'sd1);
		send_pose(-32'sd3277, 32'sd0);
		// coordinate extremes, windows far outside memory
		send_pose(32'sh7fffffff, 32'sh7fffffff);
		send_pose(32'sh80000000, 32'sh80000000);
		send_pose(32'sh7fffffff, 32'sh80000000);
		send_pose(32'sh80000000, 32'sh7fffffff);
		// last cell, window partly above memory
		send_write(16'hffff, 8'sd100);
		send_pose(32'(255 * 3277), 32'(255 * 3277));
		send_pose(32'(255 * 3277 + 3276), 32'(255 * 3277 + 3276));
		send_write(16'hffff, 8'sd0);

		// ---- random traffic, one register setting per phase
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: apply_setting(RST_GRID_WIDTH, RST_CELL_SIZE, 32'sd0, 32'sd0,
						 RST_THRESHOLD);
				// narrowest grid and cell, every known cell an obstacle
				1: apply_setting(16'd1, 32'd1, 32'sd0, -32'sd100, -8'sd1);
				// widest grid, largest cell, origins at the extremes: saturates
				2: apply_setting(16'hffff, 32'hffffffff, 32'sh7fffffff,
						 32'sh80000000, 8'sd0);
				// 1 m cells, negative origin, nothing counts as an obstacle
				3: apply_setting(16'd200, 32'd65536, -32'sd229376, 32'sd147456,
						 8'sd100);
				// zero width and zero cell size both behave as 1
				4: apply_setting(16'd0, 32'd0, 32'sd7, -32'sd3, 8'sd50);
				default: apply_setting(
					($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
								    : 16'($urandom_range(1, 512)),
					($urandom_range(0, 3) == 0) ? $urandom
								    : $urandom_range(1, 200000),
					$urandom, $urandom, any_cell_value());
			endcase
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				if (n % 40 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				// occasional full pause until the pipeline is empty
				if ($urandom_range(0, 63) == 0)
					drain_results();
				roll = $urandom_range(0, 99);
				if (roll < 35) begin
					// writes mostly land in the last pose's window
					if ($urandom_range(0, 2) != 0) begin
						dx = $signed($urandom_range(0, 2 * HALF_WINDOW - 1)) - HALF_WINDOW;
						dy = $signed($urandom_range(0, 2 * HALF_WINDOW - 1)) - HALF_WINDOW;
						addr = 16'(longint'(target) + longint'(dy) * cur_w + dx);
					end else begin
						addr = 16'($urandom);
					end
					send_write(addr, any_cell_value());
				end else if (roll < 87) begin
					// well-formed pose on a grid cell, sometimes the same cell again
					if ($urandom_range(0, 4) != 0)
						target = $urandom_range(0, GRID_CELLS - 1);
					pose_at_cell(target, px, py);
					send_pose(px, py);
				end else begin
					send_pose($urandom, $urandom);
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("summary: %0d requests, %0d pose checks, %0d collisions reported",
			 n_requests, n_poses, collisions_seen);
		$display("summary: %0d register settings incl. zero, minimum and maximum values",
			 n_settings);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

### files.f
hw/rtl/gfcc_pkg.sv
hw/rtl/gfcc_div.sv
hw/rtl/grid_footprint_collision_check_top.sv
sim/collision_check_monitor.sv
sim/tb_top.sv
